// ===== rtl/ftud_pkg.sv =====
// ---------------------------------------------------------------------------
// ftud_pkg: shared types and constants for the fat-tree up/down port select
// Sizes, field widths, register indexes and the scan beat struct.
// ---------------------------------------------------------------------------
`default_nettype none

package ftud_pkg;

   localparam int PORTS      = 16;
   localparam int VCS        = 4;
   localparam int HALF_PORTS = PORTS / 2;
   localparam int DEPTH      = HALF_PORTS * VCS;

   localparam int SLOT_W  = (HALF_PORTS > 1) ? $clog2(HALF_PORTS) : 1;
   localparam int VC_W    = (VCS > 1) ? $clog2(VCS) : 1;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int AVAIL_W = 8;
   localparam int SUM_W   = AVAIL_W + VC_W + 1;

   // fixed field widths of the word formats
   localparam int PORT_W     = 4;
   localparam int OUT_VC_W   = 2;
   localparam int DEST_W     = 3;
   localparam int DRAW_W     = 8;
   localparam int UP_SLOT_W  = 3;
   localparam int IN_VC_W    = 2;
   localparam int LEVEL_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // request kinds
   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_ROUTE  = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROUTER_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_LEVEL    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVAL_PORT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPTIVE     = 2'd3;

   // one availability entry travelling into the scan unit
   typedef struct packed {
      logic              valid;
      logic              first_vc;
      logic              last_vc;
      logic              first_slot;
      logic [SLOT_W-1:0] slot;
   } scan_beat_type;

endpackage

`default_nettype wire

// ===== rtl/ftud_if.sv =====
// ---------------------------------------------------------------------------
// ftud_if: valid/ready channels of the port select unit
// Request, response and register write channels.
// ---------------------------------------------------------------------------
`default_nettype none

interface ftud_req_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [ftud_pkg::DEST_W-1:0]     dest_down_port;
   logic [ftud_pkg::DRAW_W-1:0]     random_draw;
   logic [ftud_pkg::UP_SLOT_W-1:0]  up_port_slot;
   logic [ftud_pkg::IN_VC_W-1:0]    vc_number;
   logic [ftud_pkg::AVAIL_W-1:0]    availability_value;

   modport source (output valid, kind, dest_down_port, random_draw, up_port_slot,
                   vc_number, availability_value, input ready);
   modport sink   (input valid, kind, dest_down_port, random_draw, up_port_slot,
                   vc_number, availability_value, output ready);
endinterface

interface ftud_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ftud_pkg::PORT_W-1:0]    out_port;
   logic [ftud_pkg::OUT_VC_W-1:0]  out_vc;
   logic                           last_of_run;

   modport source (output valid, out_port, out_vc, last_of_run, input ready);
   modport sink   (input valid, out_port, out_vc, last_of_run, output ready);
endinterface

interface ftud_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ftud_pkg::CSR_IDX_W-1:0]   index;
   logic [ftud_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ftud_avail_mem.sv =====
// ---------------------------------------------------------------------------
// ftud_avail_mem: VC availability store
// One write port, one registered read port; per-entry valid bits make
// never-written entries read as zero after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module ftud_avail_mem (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [ftud_pkg::ADDR_W-1:0]   wr_addr,
   input  wire logic [ftud_pkg::AVAIL_W-1:0]  wr_data,
   input  wire logic [ftud_pkg::ADDR_W-1:0]   rd_addr,
   output logic      [ftud_pkg::AVAIL_W-1:0]  rd_data
);

   logic [ftud_pkg::AVAIL_W-1:0] mem_ff [ftud_pkg::DEPTH];
   logic [ftud_pkg::DEPTH-1:0]   vld_ff;
   logic [ftud_pkg::AVAIL_W-1:0] rd_data_ff;
   logic                         rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/ftud_scan_unit.sv =====
// ---------------------------------------------------------------------------
// ftud_scan_unit: accumulate and compare unit
// Sums VC availability per upper port one entry a cycle and keeps the
// port with the largest sum (first one wins on ties).
// ---------------------------------------------------------------------------
`default_nettype none

module ftud_scan_unit (
   input  wire logic                          clock,
   input  wire ftud_pkg::scan_beat_type       beat,
   input  wire logic [ftud_pkg::AVAIL_W-1:0]  data,
   output logic      [ftud_pkg::SLOT_W-1:0]   best_slot
);

   logic [ftud_pkg::SUM_W-1:0]  sum_ff,       sum_in;
   logic [ftud_pkg::SUM_W-1:0]  best_sum_ff,  best_sum_in;
   logic [ftud_pkg::SLOT_W-1:0] best_slot_ff, best_slot_in;
   logic [ftud_pkg::SUM_W-1:0]  acc;

   always_comb begin
      acc          = (beat.first_vc ? '0 : sum_ff) + ftud_pkg::SUM_W'(data);
      sum_in       = sum_ff;
      best_sum_in  = best_sum_ff;
      best_slot_in = best_slot_ff;
      if (beat.valid) begin
         sum_in = acc;
         if (beat.last_vc && (beat.first_slot || (acc > best_sum_ff))) begin
            best_sum_in  = acc;
            best_slot_in = beat.slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      best_sum_ff  <= best_sum_in;
      best_slot_ff <= best_slot_in;
   end

   assign best_slot = best_slot_ff;

endmodule

`default_nettype wire

// ===== rtl/fat_tree_updown_port_select_unit.sv =====
// ---------------------------------------------------------------------------
// fat_tree_updown_port_select_unit: up/down output port select
// Routing unit for one input port of a fat-tree router. Keeps per-VC
// availability of the upper ports and picks the output port of a route.
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake      word
//  req_ch   in   valid/ready    kind, dest, draw, slot, vc, availability
//  rsp_ch   out  valid/ready    out_port, out_vc, last_of_run
//  csr_ch   in   valid/ready    register index, write data (always ready)
//
//  Update word: written straight into the availability store.
//  Route word, downward or random upward: one rsp per VC.
//  Route word, adaptive upward: the single read port of the store sweeps
//  every entry once (ST_SCAN, then ST_DRAIN), then one rsp per VC.
//  Reset (synchronous) clears control and store valid bits.
//  req_ch is ready only in idle; a stalled rsp_ch holds the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module fat_tree_updown_port_select_unit (
   input wire logic clock,
   input wire logic reset,
   ftud_req_if.sink   req_ch,
   ftud_rsp_if.source rsp_ch,
   ftud_csr_if.sink   csr_ch
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // configuration
   logic [ftud_pkg::LEVEL_W-1:0] router_level_ff;
   logic [ftud_pkg::LEVEL_W-1:0] top_level_ff;
   logic [ftud_pkg::PORT_W-1:0]  arrival_port_ff;
   logic                         adaptive_ff;

   // sequencer
   logic [ftud_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic [ftud_pkg::VC_W-1:0]    vcn_ff,  vcn_in;
   logic                         use_best_ff, use_best_in;
   logic [ftud_pkg::PORT_W-1:0]  port_ff, port_in;
   ftud_pkg::scan_beat_type      beat_ff, beat_in;

   logic                          req_fire, rsp_fire;
   logic                          go_up;
   logic                          wr_en;
   logic [ftud_pkg::ADDR_W-1:0]   wr_addr;
   logic [ftud_pkg::ADDR_W-1:0]   rd_addr;
   logic [ftud_pkg::AVAIL_W-1:0]  rd_data;
   logic [ftud_pkg::SLOT_W-1:0]   best_slot;
   logic                          last_vc;
   logic                          last_slot;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   // upward only from a lower port of a router not at the top level
   assign go_up = (arrival_port_ff < ftud_pkg::PORT_W'(ftud_pkg::HALF_PORTS))
                  && (router_level_ff != top_level_ff);

   // update path: out-of-range slot or VC is dropped
   assign wr_en = req_fire && (req_ch.kind == ftud_pkg::KIND_UPDATE)
                  && (req_ch.up_port_slot < ftud_pkg::HALF_PORTS)
                  && (req_ch.vc_number < ftud_pkg::VCS);
   assign wr_addr = ftud_pkg::ADDR_W'(req_ch.up_port_slot * ftud_pkg::VCS
                                      + req_ch.vc_number);
   assign rd_addr = ftud_pkg::ADDR_W'(slot_ff * ftud_pkg::VCS + vcn_ff);

   assign last_vc   = (vcn_ff == ftud_pkg::VC_W'(ftud_pkg::VCS - 1));
   assign last_slot = (slot_ff == ftud_pkg::SLOT_W'(ftud_pkg::HALF_PORTS - 1));

   always_comb begin
      state_in    = state_ff;
      slot_in     = slot_ff;
      vcn_in      = vcn_ff;
      use_best_in = use_best_ff;
      port_in     = port_ff;
      beat_in     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_ch.kind == ftud_pkg::KIND_ROUTE)) begin
               slot_in = '0;
               vcn_in  = '0;
               if (go_up && adaptive_ff) begin
                  use_best_in = 1'b1;
                  state_in    = ST_SCAN;
               end else begin
                  use_best_in = 1'b0;
                  port_in     = go_up
                     ? ftud_pkg::PORT_W'(ftud_pkg::HALF_PORTS)
                       + ftud_pkg::PORT_W'(req_ch.random_draw % ftud_pkg::HALF_PORTS)
                     : ftud_pkg::PORT_W'(req_ch.dest_down_port);
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            // one store read per cycle, tagged for the scan unit
            beat_in.valid      = 1'b1;
            beat_in.first_vc   = (vcn_ff == '0);
            beat_in.last_vc    = last_vc;
            beat_in.first_slot = (slot_ff == '0);
            beat_in.slot       = slot_ff;
            if (last_vc) begin
               vcn_in  = '0;
               slot_in = slot_ff + 1'b1;
               if (last_slot) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               vcn_in = vcn_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // last read word reaches the scan unit
            vcn_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (last_vc) begin
                  state_in = ST_IDLE;
               end else begin
                  vcn_in = vcn_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         beat_ff         <= '0;
         router_level_ff <= '0;
         top_level_ff    <= '0;
         arrival_port_ff <= '0;
         adaptive_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         beat_ff  <= beat_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               ftud_pkg::CSR_ROUTER_LEVEL:
                  router_level_ff <= csr_ch.data[ftud_pkg::LEVEL_W-1:0];
               ftud_pkg::CSR_TOP_LEVEL:
                  top_level_ff <= csr_ch.data[ftud_pkg::LEVEL_W-1:0];
               ftud_pkg::CSR_ARRIVAL_PORT:
                  arrival_port_ff <= csr_ch.data[ftud_pkg::PORT_W-1:0];
               ftud_pkg::CSR_ADAPTIVE:
                  adaptive_ff <= csr_ch.data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      vcn_ff      <= vcn_in;
      use_best_ff <= use_best_in;
      port_ff     <= port_in;
   end

   ftud_avail_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.availability_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ftud_scan_unit u_scan (
      .clock     (clock),
      .beat      (beat_ff),
      .data      (rd_data),
      .best_slot (best_slot)
   );

   assign rsp_ch.valid       = (state_ff == ST_EMIT);
   assign rsp_ch.out_port    = use_best_ff
      ? ftud_pkg::PORT_W'(ftud_pkg::HALF_PORTS) + ftud_pkg::PORT_W'(best_slot)
      : port_ff;
   assign rsp_ch.out_vc      = ftud_pkg::OUT_VC_W'(vcn_ff);
   assign rsp_ch.last_of_run = last_vc;

endmodule

`default_nettype wire

// ===== tb/sv/ftud_port_checker.sv =====
// ---------------------------------------------------------------------------
// ftud_port_checker: scoreboard for the fat-tree up/down port select unit
// Mirrors register writes and availability updates, predicts the result words
// of every accepted route word and compares them in order with rsp_ch.
// ---------------------------------------------------------------------------

module ftud_port_checker (
   input wire logic clock,
   input wire logic reset,
   ftud_req_if      req_ch,
   ftud_rsp_if      rsp_ch,
   ftud_csr_if      csr_ch,
   output int       mismatch_count,
   output int       words_due
);
   import ftud_pkg::*;

   typedef struct packed {
      logic [PORT_W-1:0]   port;
      logic [OUT_VC_W-1:0] vc;
      logic                last;
   } port_word_type;

   logic [AVAIL_W-1:0] avail_store [DEPTH];
   logic [LEVEL_W-1:0] level_q;
   logic [LEVEL_W-1:0] top_q;
   logic [PORT_W-1:0]  arrival_q;
   logic               adaptive_q;
   port_word_type      route_words_due [$];

   initial mismatch_count = 0;
   initial words_due = 0;

   task automatic report(input string what, input int want, input int got);
      mismatch_count++;
      $display("[%0t] mismatch: %s want %0d got %0d", $time, what, want, got);
   endtask

   // up from a lower port of a router not at the top level, down otherwise
   function automatic logic [PORT_W-1:0] pick_port(input logic [DEST_W-1:0] dest,
                                                  input logic [DRAW_W-1:0] draw);
      int best_slot;
      int best_sum;
      int sum;
      if (arrival_q < HALF_PORTS && level_q != top_q) begin
         if (adaptive_q) begin
            best_slot = 0;
            best_sum  = -1;
            for (int s = 0; s < HALF_PORTS; s++) begin
               sum = 0;
               for (int v = 0; v < VCS; v++)
                  sum += int'(avail_store[ADDR_W'(s*VCS + v)]);
               // strict compare keeps the lowest port on a tie
               if (sum > best_sum) begin
                  best_sum  = sum;
                  best_slot = s;
               end
            end
            return PORT_W'(HALF_PORTS + best_slot);
         end
         return PORT_W'(HALF_PORTS + (int'(draw) % HALF_PORTS));
      end
      return PORT_W'(dest);
   endfunction

   always @(posedge clock) begin : watch
      port_word_type want;
      logic [PORT_W-1:0] port;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) avail_store[ADDR_W'(i)] = '0;
         level_q    = '0;
         top_q      = '0;
         arrival_q  = '0;
         adaptive_q = 1'b0;
         route_words_due.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_ROUTER_LEVEL: level_q    = csr_ch.data[LEVEL_W-1:0];
               CSR_TOP_LEVEL:    top_q      = csr_ch.data[LEVEL_W-1:0];
               CSR_ARRIVAL_PORT: arrival_q  = csr_ch.data[PORT_W-1:0];
               CSR_ADAPTIVE:     adaptive_q = csr_ch.data[0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (route_words_due.size() == 0) begin
               report("result word with nothing due, out_port", -1,
                      int'(rsp_ch.out_port));
            end else begin
               want = route_words_due.pop_front();
               if (rsp_ch.out_port !== want.port)
                  report("out_port", int'(want.port), int'(rsp_ch.out_port));
               if (rsp_ch.out_vc !== want.vc)
                  report("out_vc", int'(want.vc), int'(rsp_ch.out_vc));
               if (rsp_ch.last_of_run !== want.last)
                  report("last_of_run", int'(want.last), int'(rsp_ch.last_of_run));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.kind == KIND_UPDATE) begin
               if (req_ch.up_port_slot < HALF_PORTS && req_ch.vc_number < VCS)
                  avail_store[ADDR_W'(req_ch.up_port_slot*VCS + req_ch.vc_number)] =
                     req_ch.availability_value;
            end else begin
               port = pick_port(req_ch.dest_down_port, req_ch.random_draw);
               for (int v = 0; v < VCS; v++) begin
                  want.port = port;
                  want.vc   = OUT_VC_W'(v);
                  want.last = (v == VCS - 1);
                  route_words_due.push_back(want);
               end
            end
         end
      end
      words_due = route_words_due.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: testbench top of the fat-tree up/down port select unit
// Directed words for every routing case, then random phases under random
// register settings with random idling on both channels and one long
// response stall. ftud_port_checker predicts and compares.
// ---------------------------------------------------------------------------

module tb_top;
   import ftud_pkg::*;

   localparam int SETTLE_CYCLES = 48;
   localparam int LONG_HOLD     = 400;    // response back-pressure stretch
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_WORDS   = 21;

   logic clock;
   logic reset;

   ftud_req_if req_ch ();
   ftud_rsp_if rsp_ch ();
   ftud_csr_if csr_ch ();

   int mismatch_count;
   int words_due;
   int cycle_count;

   // idling control for sender and receiver
   bit sender_steady;
   bit receiver_steady;
   bit pressure_req;
   logic hold_rsp;

   fat_tree_updown_port_select_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ftud_port_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatch_count),
      .words_due      (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: also catches result words that never arrive
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // long response stall, counted here while the sender keeps offering words
   initial begin
      hold_rsp <= 1'b0;
      wait (pressure_req);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // response side: random wait before each word, ready held until taken
   initial begin : receiver
      int gap;
      rsp_ch.ready <= 1'b0;
      forever begin
         gap = receiver_steady ? 0 : $urandom_range(0, 14);
         if (gap > 0 || hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (hold_rsp) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // valid stays high after a handshake; the next call lowers it or reuses it
   task automatic send_word(input logic                 kind,
                            input logic [DEST_W-1:0]    dest,
                            input logic [DRAW_W-1:0]    draw,
                            input logic [UP_SLOT_W-1:0] slot,
                            input logic [IN_VC_W-1:0]   vcn,
                            input logic [AVAIL_W-1:0]   avail);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.kind               <= kind;
      req_ch.dest_down_port     <= dest;
      req_ch.random_draw        <= draw;
      req_ch.up_port_slot       <= slot;
      req_ch.vc_number          <= vcn;
      req_ch.availability_value <= avail;
      req_ch.valid              <= 1'b1;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
   endtask

   // unused fields of a word carry random values
   task automatic send_route(input logic [DEST_W-1:0] dest, input logic [DRAW_W-1:0] draw);
      send_word(KIND_ROUTE, dest, draw, UP_SLOT_W'($urandom_range(0, 7)),
                IN_VC_W'($urandom_range(0, 3)), AVAIL_W'($urandom_range(0, 255)));
   endtask

   task automatic send_update(input logic [UP_SLOT_W-1:0] slot,
                              input logic [IN_VC_W-1:0]   vcn,
                              input logic [AVAIL_W-1:0]   avail);
      send_word(KIND_UPDATE, DEST_W'($urandom_range(0, 7)), DRAW_W'($urandom_range(0, 255)),
                slot, vcn, avail);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0]  idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      csr_ch.valid <= 1'b0;
   endtask

   // drain: stop offering, wait for every due word, then let the block go idle
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_word();
      int pick;
      logic [AVAIL_W-1:0] avail;
      if ($urandom_range(0, 99) < 35) begin
         pick = $urandom_range(0, 3);
         // lean on the extremes so ties and saturated sums come up
         avail = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 :
                 AVAIL_W'($urandom_range(0, 255));
         send_update(UP_SLOT_W'($urandom_range(0, 7)), IN_VC_W'($urandom_range(0, 3)),
                     avail);
      end else begin
         send_route(DEST_W'($urandom_range(0, 7)), DRAW_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] level;
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      pressure_req    = 1'b0;
      reset                     <= 1'b1;
      req_ch.valid              <= 1'b0;
      req_ch.kind               <= KIND_UPDATE;
      req_ch.dest_down_port     <= '0;
      req_ch.random_draw        <= '0;
      req_ch.up_port_slot       <= '0;
      req_ch.vc_number          <= '0;
      req_ch.availability_value <= '0;
      csr_ch.valid              <= 1'b0;
      csr_ch.index              <= CSR_ROUTER_LEVEL;
      csr_ch.data               <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: level equals top level, so routes go down
      send_route(3'd0, 8'd255);
      send_route(3'd7, 8'd0);
      settle();

      // leaf router, tree with eight levels, lower arrival port: random upward
      write_reg(CSR_ROUTER_LEVEL, 4'd0);
      write_reg(CSR_TOP_LEVEL, 4'd7);
      write_reg(CSR_ARRIVAL_PORT, 4'd0);
      write_reg(CSR_ADAPTIVE, 4'd0);
      send_route(3'd5, 8'd0);
      send_route(3'd5, 8'd255);
      send_route(3'd2, 8'd7);
      send_route(3'd2, 8'd8);
      settle();

      // adaptive upward
      write_reg(CSR_ADAPTIVE, 4'd1);
      send_route(3'd1, 8'd3);            // empty store, tie goes to port 8
      send_update(3'd7, 2'd3, 8'd255);
      send_route(3'd1, 8'd3);            // top upper port alone
      send_update(3'd2, 2'd0, 8'd255);
      send_route(3'd1, 8'd3);            // tie between ports 10 and 15
      send_update(3'd7, 2'd0, 8'd1);
      send_route(3'd1, 8'd3);            // sum carries past eight bits
      for (int v = 0; v < VCS; v++) send_update(3'd4, IN_VC_W'(v), 8'd255);
      send_route(3'd1, 8'd3);            // full port wins
      settle();

      // arrival on an upper port goes down below the top level too
      write_reg(CSR_ARRIVAL_PORT, 4'd15);
      send_route(3'd3, 8'd200);
      settle();

      // top router: a lower arrival port also goes down
      write_reg(CSR_ARRIVAL_PORT, 4'd7);
      write_reg(CSR_ROUTER_LEVEL, 4'd7);
      send_route(3'd5, 8'd17);
      settle();

      // level above the top index: only equality counts, so it goes up
      write_reg(CSR_ROUTER_LEVEL, 4'd5);
      write_reg(CSR_TOP_LEVEL, 4'd3);
      send_route(3'd6, 8'd99);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         level = CSR_DATA_W'($urandom_range(0, 15));
         write_reg(CSR_ROUTER_LEVEL, level);
         // mostly not at the top level, where the upward choice is made
         write_reg(CSR_TOP_LEVEL, ($urandom_range(0, 3) == 0) ? level :
                                  CSR_DATA_W'($urandom_range(0, 15)));
         write_reg(CSR_ARRIVAL_PORT, ($urandom_range(0, 3) != 0) ?
                                     CSR_DATA_W'($urandom_range(0, 7)) :
                                     CSR_DATA_W'($urandom_range(0, 15)));
         write_reg(CSR_ADAPTIVE, CSR_DATA_W'($urandom_range(0, 15)));
         sender_steady   = ($urandom_range(0, 2) == 0);
         receiver_steady = ($urandom_range(0, 2) == 0);
         if (phase == 2) begin
            sender_steady = 1'b1;
            pressure_req  = 1'b1;
         end
         repeat (PHASE_WORDS) random_word();
      end

      settle();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
